// ----- hw/rtl/gbca_pkg.sv -----
// ----------------------------------------------------------------------------
// gbca_pkg: shared constants and types of the grey box-count accumulator
// Frame geometry limits, box size range, field widths and register indices.
// ----------------------------------------------------------------------------
package gbca_pkg;

  // Frame and box geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int LARGEST_BOX = 64;
  localparam int NUM_SIZES   = $clog2(LARGEST_BOX);
  localparam int BOX_MASK    = LARGEST_BOX - 1;

  // Pixel position widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = 11;

  // Field widths
  localparam int GREY_W  = 8;
  localparam int SIZE_W  = 3;
  localparam int COUNT_W = 26;
  localparam int ENTRY_W = 2 * GREY_W;
  localparam int RIDX_W  = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_SEL_X       = 3'd1,
    CFG_SEL_Y       = 3'd2,
    CFG_SEL_WIDTH   = 3'd3,
    CFG_SEL_HEIGHT  = 3'd4
  } cfg_reg_e;

endpackage

// ----- hw/rtl/grey_box_count_accumulator.sv -----
// ----------------------------------------------------------------------------
// grey_box_count_accumulator
// Differential box counting over a selection of a grey-level pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in_valid_i/in_ready_o channel in raster order, one
// grey byte and a frame_end flag per transaction. Inside the selection (cut
// to whole multiples of the largest box) every pixel updates the min/max
// entry of its box for each box size 2..LARGEST_BOX; each size keeps its
// own entry memory with one write port and one registered read port. A box
// finishing on its bottom-right pixel adds (max-min)/size+1 to its count.
// One pixel is taken per cycle while in_ready_o is high; its memory read
// is issued on the accept edge and the update stage merges it, with the
// last write forwarded to cover back-to-back hits on the same entry.
// The pixel carrying frame_end loads the six counts into an output shift
// register from the update stage; they leave on out_valid_o / out_ready_i,
// smallest box first, last_o on the largest. Counts clear on that load,
// pixel position when frame_end is accepted. If another frame end reaches
// the update stage while earlier counts are still leaving, in_ready_o
// drops until the result register frees up; otherwise a stalled receiver
// does not hold the pixel stream. Reset restores the default registers
// and clears counts and position; entry memories need no clearing.
// ----------------------------------------------------------------------------
module grey_box_count_accumulator import gbca_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [GREY_W-1:0]     red_level_i,
  input  logic                  frame_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SIZE_W-1:0]     size_log2_o,
  output logic [COUNT_W-1:0]    box_count_o,
  output logic                  last_o
);

  // Configuration registers
  logic [10:0] img_width_q, sel_width_q, sel_height_q;
  logic [9:0]  sel_x_q, sel_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= 11'd1024;
      sel_x_q      <= '0;
      sel_y_q      <= '0;
      sel_width_q  <= 11'd1024;
      sel_height_q <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH: img_width_q  <= cfg_wdata_i[10:0];
        CFG_SEL_X:       sel_x_q      <= cfg_wdata_i[9:0];
        CFG_SEL_Y:       sel_y_q      <= cfg_wdata_i[9:0];
        CFG_SEL_WIDTH:   sel_width_q  <= cfg_wdata_i[10:0];
        CFG_SEL_HEIGHT:  sel_height_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // Pixel position and selection test
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W:0]   row_len;
  logic [COL_W:0]   col_inc;
  logic [10:0]      sel_w_trunc, sel_h_trunc;
  logic             in_sel;
  logic [COL_W-1:0] lx;
  logic [ROW_W-1:0] ly;
  logic             in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    if (img_width_q == '0) begin
      row_len = (COL_W+1)'(1);
    end else if (32'(img_width_q) >= MAX_WIDTH) begin
      row_len = (COL_W+1)'(MAX_WIDTH);
    end else begin
      row_len = (COL_W+1)'(img_width_q);
    end
  end

  assign sel_w_trunc = sel_width_q  & ~11'(BOX_MASK);
  assign sel_h_trunc = sel_height_q & ~11'(BOX_MASK);

  assign lx = COL_W'(32'(col_q) - 32'(sel_x_q));
  assign ly = ROW_W'(32'(row_q) - 32'(sel_y_q));

  assign in_sel = (32'(col_q) >= 32'(sel_x_q)) && (32'(lx) < 32'(sel_w_trunc)) &&
                  (32'(row_q) >= 32'(sel_y_q)) && (32'(ly) < 32'(sel_h_trunc));

  assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (frame_end_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= row_len) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Update stage
  logic              s1_valid_q, s1_fend_q, s1_insel_q;
  logic [GREY_W-1:0] s1_grey_q;
  logic [COL_W-1:0]  s1_lx_q;
  logic [ROW_W-1:0]  s1_ly_q;
  logic              s1_stall, s1_go;
  logic              res_busy_q;
  logic [RIDX_W-1:0] res_idx_q;
  logic              res_can_load;
  logic              out_accept;

  assign out_accept   = out_valid_o && out_ready_i;
  assign res_can_load = !res_busy_q || (out_accept && last_o);
  assign s1_stall     = s1_valid_q && s1_fend_q && !res_can_load;
  assign s1_go        = s1_valid_q && !s1_stall;
  assign in_ready_o   = !s1_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_fend_q  <= frame_end_i;
      s1_insel_q <= in_sel;
      s1_grey_q  <= red_level_i;
      s1_lx_q    <= lx;
      s1_ly_q    <= ly;
    end
  end

  // Per-size entry memories, extremes merge and count increment
  logic [COUNT_W-1:0] cnt_q   [NUM_SIZES];
  logic [COUNT_W-1:0] cnt_upd [NUM_SIZES];

  for (genvar k = 1; k <= NUM_SIZES; k++) begin : g_size
    localparam int AW    = COL_W - k;
    localparam int DEPTH = MAX_WIDTH >> k;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_q, fwd_data_q, base, wr_data;
    logic [AW-1:0]      rd_addr, wr_addr, fwd_addr_q;
    logic               fwd_valid_q;
    logic               box_start, box_done, wr_en;
    logic [GREY_W-1:0]  mx, mn, span;

    assign rd_addr   = lx[COL_W-1:k];
    assign wr_addr   = s1_lx_q[COL_W-1:k];
    assign box_start = (~|s1_lx_q[k-1:0]) && (~|s1_ly_q[k-1:0]);
    assign box_done  = (&s1_lx_q[k-1:0]) && (&s1_ly_q[k-1:0]);
    assign wr_en     = s1_go && s1_insel_q;

    // Take the last write when it hit the same entry as this read
    assign base = (fwd_valid_q && fwd_addr_q == wr_addr) ? fwd_data_q : rd_q;

    always_comb begin
      if (box_start) begin
        mx = s1_grey_q;
        mn = s1_grey_q;
      end else begin
        mx = (s1_grey_q > base[ENTRY_W-1:GREY_W]) ? s1_grey_q : base[ENTRY_W-1:GREY_W];
        mn = (s1_grey_q < base[GREY_W-1:0])       ? s1_grey_q : base[GREY_W-1:0];
      end
    end

    assign wr_data = {mx, mn};
    assign span    = (mx - mn) >> k;

    assign cnt_upd[k-1] = (wr_en && box_done) ?
                          cnt_q[k-1] + COUNT_W'(span) + COUNT_W'(1) : cnt_q[k-1];

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (in_accept) begin
        rd_q <= mem[rd_addr];
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        fwd_addr_q <= wr_addr;
        fwd_data_q <= wr_data;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fwd_valid_q <= 1'b0;
      end else if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // Counts and result shift register
  logic [COUNT_W-1:0] res_q [NUM_SIZES];
  logic               res_load;

  assign res_load = s1_go && s1_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        cnt_q[i] <= res_load ? '0 : cnt_upd[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        res_q[i] <= cnt_upd[i];
      end
    end else if (out_accept) begin
      // advance to the next box size
      for (int i = 0; i < NUM_SIZES - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_busy_q <= 1'b0;
      res_idx_q  <= '0;
    end else if (res_load) begin
      res_busy_q <= 1'b1;
      res_idx_q  <= '0;
    end else if (out_accept) begin
      if (last_o) begin
        res_busy_q <= 1'b0;
        res_idx_q  <= '0;
      end else begin
        res_idx_q <= res_idx_q + RIDX_W'(1);
      end
    end
  end

  assign out_valid_o = res_busy_q;
  assign box_count_o = res_q[0];
  assign size_log2_o = SIZE_W'(res_idx_q) + SIZE_W'(1);
  assign last_o      = (32'(res_idx_q) == NUM_SIZES - 1);

  // Checks
  a_stall_only_on_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_fend_q && res_busy_q))
    else $error("input stalled without a pending frame end");

  a_results_follow_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (out_valid_o && res_idx_q == '0))
    else $error("frame end did not start the result sequence");

  a_counts_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (cnt_q[0] == '0 && cnt_q[NUM_SIZES-1] == '0))
    else $error("counts not cleared after frame end");

  a_position_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && frame_end_i) |=> (col_q == '0 && row_q == '0))
    else $error("pixel position not cleared after frame end");

endmodule
